// ----- hdl/stia_pkg.sv -----
package stia_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;

    localparam int CFG_W     = 5;
    localparam int KEY_W     = 16;
    localparam int IDX_W     = 4;
    localparam int AID_W     = 16;
    // largest slot count the active_slots register can select
    localparam int ACT_MAX   = 2**CFG_W - 1;
    localparam logic [CFG_W-1:0] ACTIVE_RST = CFG_W'(16);

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_FIND   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_MISS      = 2'd1,
        ST_ID_ZERO   = 2'd2,
        ST_EXHAUSTED = 2'd3
    } t_status;

    typedef struct packed {
        t_func            func;
        logic [KEY_W-1:0] id_key;
    } t_req;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot_index;
        logic [AID_W-1:0] assigned_id;
        logic             any_used;
    } t_rsp;

    typedef enum logic {
        CS_IDLE   = 1'b0,
        CS_COMMIT = 1'b1
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctrl_cmd;

    typedef struct packed {
        logic rsp_busy;
    } t_dp_status;

endpackage

// ----- hdl/stia_ctrl.sv -----
module stia_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    output logic                  o_req_ready,
    input  stia_pkg::t_dp_status  i_dp_status,
    output stia_pkg::t_ctrl_cmd   o_cmd
);

    stia_pkg::t_ctrl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stia_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            stia_pkg::CS_IDLE: begin
                o_req_ready = i_rst_n;
                if (i_req_valid && i_rst_n) begin
                    o_cmd.capture = 1'b1;
                    n_state       = stia_pkg::CS_COMMIT;
                end
            end
            stia_pkg::CS_COMMIT: begin
                // hold until the response register can take the result
                if (!i_dp_status.rsp_busy) begin
                    o_cmd.commit = 1'b1;
                    n_state      = stia_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = stia_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/stia_datapath.sv -----
module stia_datapath #(
    parameter int SLOTS   = stia_pkg::SLOTS_DEF,
    parameter int ID_BITS = stia_pkg::ID_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [stia_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  stia_pkg::t_req               i_req,
    input  stia_pkg::t_ctrl_cmd          i_cmd,
    output stia_pkg::t_dp_status         o_dp_status,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output stia_pkg::t_rsp               o_rsp
);

    // Slots above the largest active count are never claimed, so only those
    // that the register can reach are stored.
    localparam int TBL    = (SLOTS < stia_pkg::ACT_MAX) ? SLOTS : stia_pkg::ACT_MAX;
    localparam int TBL_IW = $clog2(TBL);
    localparam int CMP_W  = (ID_BITS > stia_pkg::KEY_W) ? ID_BITS : stia_pkg::KEY_W;

    logic [stia_pkg::CFG_W-1:0] r_active;
    logic [TBL-1:0]             r_used, n_used;
    logic [ID_BITS-1:0]         r_id [TBL];
    logic [ID_BITS-1:0]         r_id_counter, n_id_counter;
    logic [TBL-1:0]             r_match, n_match;
    stia_pkg::t_func            r_func;
    logic                       r_key_zero;
    stia_pkg::t_rsp             r_rsp, n_rsp;
    logic                       r_rsp_valid;

    logic [TBL-1:0]    active_mask;
    logic [TBL-1:0]    free_vec;
    logic              free_any, match_any;
    logic [TBL_IW-1:0] free_idx, match_idx, hit_idx;
    logic              id_write;

    // index i is active when below the register value; a register value above
    // the stored slot count marks every stored slot active, so no saturation is needed
    always_comb begin
        for (int i = 0; i < TBL; i++) begin
            active_mask[i] = (stia_pkg::CFG_W'(i) < r_active);
        end
    end

    always_comb begin
        for (int i = 0; i < TBL; i++) begin
            n_match[i] = r_used[i] && active_mask[i]
                && (CMP_W'(r_id[i]) == CMP_W'(i_req.id_key));
        end
    end

    assign free_vec  = ~r_used & active_mask;
    assign free_any  = |free_vec;
    assign match_any = |r_match;

    always_comb begin
        free_idx  = '0;
        match_idx = '0;
        for (int i = TBL - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                free_idx = TBL_IW'(i);
            end
            if (r_match[i]) begin
                match_idx = TBL_IW'(i);
            end
        end
    end

    always_comb begin
        n_used       = r_used;
        n_id_counter = r_id_counter;
        id_write     = 1'b0;
        hit_idx      = '0;
        n_rsp        = '0;
        n_rsp.status = stia_pkg::ST_OK;
        case (r_func)
            stia_pkg::FUNC_ADD: begin
                if (!free_any) begin
                    n_rsp.status = stia_pkg::ST_MISS;
                end else if (&r_id_counter) begin
                    n_rsp.status = stia_pkg::ST_EXHAUSTED;
                end else begin
                    n_id_counter      = r_id_counter + 1'b1;
                    hit_idx           = free_idx;
                    n_used[free_idx]  = 1'b1;
                    id_write          = 1'b1;
                    n_rsp.slot_index  = stia_pkg::IDX_W'(free_idx);
                    n_rsp.assigned_id = stia_pkg::AID_W'(n_id_counter);
                end
            end
            stia_pkg::FUNC_FIND, stia_pkg::FUNC_REMOVE: begin
                if (r_key_zero) begin
                    n_rsp.status = stia_pkg::ST_ID_ZERO;
                end else if (!match_any) begin
                    n_rsp.status = stia_pkg::ST_MISS;
                end else begin
                    n_rsp.slot_index = stia_pkg::IDX_W'(match_idx);
                    if (r_func == stia_pkg::FUNC_REMOVE) begin
                        n_used[match_idx] = 1'b0;
                    end
                end
            end
            default: begin
                n_used = '0;
            end
        endcase
        n_rsp.any_used = |(n_used & active_mask);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= stia_pkg::ACTIVE_RST;
            r_used       <= '0;
            r_id_counter <= '0;
            r_rsp_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            if (i_cmd.commit) begin
                r_used       <= n_used;
                r_id_counter <= n_id_counter;
                r_rsp_valid  <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_match    <= n_match;
            r_func     <= i_req.func;
            r_key_zero <= (i_req.id_key == '0);
        end
        if (i_cmd.commit) begin
            r_rsp <= n_rsp;
            if (id_write) begin
                r_id[hit_idx] <= n_id_counter;
            end
        end
    end

    assign o_dp_status.rsp_busy = r_rsp_valid && !i_rsp_ready;
    assign o_rsp_valid          = r_rsp_valid;
    assign o_rsp                = r_rsp;

endmodule

// ----- hdl/slot_table_id_allocator_unit.sv -----
// Channel     Direction  Signals                         Moves
// request     in         i_req_valid / o_req_ready       i_req  (func, id_key)
// response    out        o_rsp_valid / i_rsp_ready       o_rsp  (status, slot_index,
//                                                               assigned_id, any_used)
// config      in         i_cfg_we                        i_cfg_wdata (active_slots)
//
// Each request has an accept cycle, which registers the id compare of
// every stored slot, and a commit cycle, which priority-encodes and updates the table.
// A new request is taken in the cycle after commit.
// Reset clears the used marks and the id counter and sets active_slots to 16.
// Commit waits while a previous response is still held in the output register.
module slot_table_id_allocator_unit #(
    parameter int SLOTS   = stia_pkg::SLOTS_DEF,
    parameter int ID_BITS = stia_pkg::ID_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [stia_pkg::CFG_W-1:0]  i_cfg_wdata,
    input  logic                        i_req_valid,
    output logic                        o_req_ready,
    input  stia_pkg::t_req              i_req,
    output logic                        o_rsp_valid,
    input  logic                        i_rsp_ready,
    output stia_pkg::t_rsp              o_rsp
);

    stia_pkg::t_ctrl_cmd  cmd;
    stia_pkg::t_dp_status dp_status;

    stia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    stia_datapath #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_dp_status (dp_status),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ----- hdl/stia_checker.sv -----
module stia_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [stia_pkg::CFG_W-1:0]  i_cfg_wdata,
    input logic                        i_req_valid,
    input logic                        o_req_ready,
    input stia_pkg::t_req              i_req,
    input logic                        o_rsp_valid,
    input logic                        i_rsp_ready,
    input stia_pkg::t_rsp              o_rsp
);

    logic req_acc;
    assign req_acc = i_req_valid && o_req_ready;

    // a stalled response keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response changed while stalled");

    // one request in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> !o_req_ready)
        else $error("request taken during commit");

    // a fresh response must follow an accepted request
    a_rsp_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(req_acc, 2))
        else $error("response without matching request");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != stia_pkg::ST_OK)
        |-> (o_rsp.slot_index == '0) && (o_rsp.assigned_id == '0))
        else $error("failed response carries slot or id");

    a_id_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.assigned_id != '0) |-> o_rsp.status == stia_pkg::ST_OK)
        else $error("id given on failed request");

endmodule

bind slot_table_id_allocator_unit stia_checker u_stia_checker (.*);

// ----- dv/slot_table_id_allocator_unit_test.sv -----
`timescale 1ns / 1ps

module slot_table_id_allocator_unit_test;

    typedef struct packed {
        logic [stia_pkg::SLOTS_DEF-1:0]                     used;
        logic [stia_pkg::SLOTS_DEF-1:0][stia_pkg::AID_W-1:0] ids;
        logic [stia_pkg::AID_W-1:0]                         counter;
        logic [stia_pkg::CFG_W-1:0]                         active;
    } t_slot_table;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [stia_pkg::CFG_W-1:0] i_cfg_wdata;
    logic                       i_req_valid;
    logic                       o_req_ready;
    stia_pkg::t_req             i_req;
    logic                       o_rsp_valid;
    logic                       i_rsp_ready;
    stia_pkg::t_rsp             o_rsp;

    // table seen by the checker (updated on accept) and by the generator
    t_slot_table      dut_table;
    t_slot_table      gen_table;
    stia_pkg::t_req   req_backlog[$];
    stia_pkg::t_rsp   pending_rsp[$];
    stia_pkg::t_rsp   rsp_want;
    int unsigned      req_issued;
    int unsigned      req_accepted;
    int               errors;
    int               req_gap_pct;
    int               rsp_stall_pct;

    slot_table_id_allocator_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    function automatic stia_pkg::t_rsp run_table_op(inout t_slot_table tbl,
                                                    input stia_pkg::t_req rq);
        stia_pkg::t_rsp rsp;
        int             n;
        int             hit;
        rsp = '0;
        rsp.status = stia_pkg::ST_OK;
        n = (tbl.active > stia_pkg::SLOTS_DEF) ? stia_pkg::SLOTS_DEF : int'(tbl.active);
        hit = -1;
        case (rq.func)
            stia_pkg::FUNC_ADD: begin
                for (int i = 0; i < n; i++)
                    if (hit < 0 && !tbl.used[i]) hit = i;
                // full is checked before the counter
                if (hit < 0) begin
                    rsp.status = stia_pkg::ST_MISS;
                end else if (tbl.counter == '1) begin
                    rsp.status = stia_pkg::ST_EXHAUSTED;
                end else begin
                    tbl.counter = tbl.counter + 1'b1;
                    tbl.used[hit] = 1'b1;
                    tbl.ids[hit] = tbl.counter;
                    rsp.slot_index = stia_pkg::IDX_W'(hit);
                    rsp.assigned_id = tbl.counter;
                end
            end
            stia_pkg::FUNC_FIND, stia_pkg::FUNC_REMOVE: begin
                if (rq.id_key == '0) begin
                    rsp.status = stia_pkg::ST_ID_ZERO;
                end else begin
                    for (int i = 0; i < n; i++)
                        if (hit < 0 && tbl.used[i] && tbl.ids[i] == rq.id_key) hit = i;
                    if (hit < 0) begin
                        rsp.status = stia_pkg::ST_MISS;
                    end else begin
                        rsp.slot_index = stia_pkg::IDX_W'(hit);
                        if (rq.func == stia_pkg::FUNC_REMOVE) tbl.used[hit] = 1'b0;
                    end
                end
            end
            default: begin
                // clear drops inactive slots too
                tbl.used = '0;
            end
        endcase
        for (int i = 0; i < n; i++)
            if (tbl.used[i]) rsp.any_used = 1'b1;
        return rsp;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // monitor: check responses, then record the request accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_rsp_valid && i_rsp_ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: response with none expected, expected nothing, actual %h",
                             $time, o_rsp);
                    errors++;
                end else begin
                    rsp_want = pending_rsp.pop_front();
                    check_field("status", rsp_want.status, o_rsp.status);
                    check_field("slot_index", rsp_want.slot_index, o_rsp.slot_index);
                    check_field("assigned_id", rsp_want.assigned_id, o_rsp.assigned_id);
                    check_field("any_used", rsp_want.any_used, o_rsp.any_used);
                end
            end
            if (i_req_valid && o_req_ready) begin
                pending_rsp.push_back(run_table_op(dut_table, i_req));
                req_accepted++;
            end
            if (i_cfg_we) dut_table.active = i_cfg_wdata;
        end
    end

    // driver: hold the request until accepted, then advance or idle
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_req_valid || req_issued == req_accepted) begin
                if (req_backlog.size() != 0 && $urandom_range(0, 99) >= req_gap_pct) begin
                    i_req       <= req_backlog.pop_front();
                    i_req_valid <= 1'b1;
                    req_issued++;
                end else begin
                    i_req_valid <= 1'b0;
                end
            end
            i_rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
        end
    end

    task automatic queue_req(stia_pkg::t_func f, logic [stia_pkg::KEY_W-1:0] key);
        stia_pkg::t_req rq;
        rq.func   = f;
        rq.id_key = key;
        void'(run_table_op(gen_table, rq));
        req_backlog.push_back(rq);
    endtask

    task automatic wait_drained();
        while (!(req_backlog.size() == 0 && req_issued == req_accepted &&
                 pending_rsp.size() == 0))
            @(posedge i_clk);
    endtask

    task automatic set_active(logic [stia_pkg::CFG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        gen_table.active = v;
        @(posedge i_clk);
    endtask

    initial begin
        int                          r;
        int                          nact;
        int                          nlive;
        int                          bound;
        int                          act_list[8];
        logic [stia_pkg::KEY_W-1:0]  live[stia_pkg::SLOTS_DEF];
        logic [stia_pkg::KEY_W-1:0]  key;
        stia_pkg::t_func             f;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = stia_pkg::ACTIVE_RST;
        i_req_valid   = 1'b0;
        i_req         = '0;
        i_rsp_ready   = 1'b0;
        req_issued    = 0;
        req_accepted  = 0;
        errors        = 0;
        req_gap_pct   = 0;
        rsp_stall_pct = 0;
        dut_table        = '0;
        dut_table.active = stia_pkg::ACTIVE_RST;
        gen_table        = dut_table;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table, id zero, ids 1..3, remove and reuse of a middle slot
        queue_req(stia_pkg::FUNC_FIND, '0);
        queue_req(stia_pkg::FUNC_REMOVE, '0);
        queue_req(stia_pkg::FUNC_FIND, 16'hFFFF);
        queue_req(stia_pkg::FUNC_CLEAR, 16'hFFFF);
        repeat (3) queue_req(stia_pkg::FUNC_ADD, 16'hFFFF);
        queue_req(stia_pkg::FUNC_FIND, 16'd2);
        queue_req(stia_pkg::FUNC_REMOVE, 16'd2);
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_REMOVE, 16'd1);
        // no active slot
        set_active(5'd0);
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_FIND, 16'd4);
        // one active slot: add then full, used slot 1 out of range
        set_active(5'd1);
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_FIND, 16'd4);

        act_list = '{16, 1, 3, 16, 2, 8, 31, 0};
        for (int p = 0; p < 8; p++) begin
            set_active(p == 7 ? stia_pkg::CFG_W'($urandom_range(1, 16))
                              : stia_pkg::CFG_W'(act_list[p]));
            case (p % 4)
                0: begin req_gap_pct = 0;  rsp_stall_pct = 0;  end
                1: begin req_gap_pct = 78; rsp_stall_pct = 0;  end
                2: begin req_gap_pct = 0;  rsp_stall_pct = 78; end
                default: begin req_gap_pct = 18; rsp_stall_pct = 18; end
            endcase
            nact = (gen_table.active > stia_pkg::SLOTS_DEF) ? stia_pkg::SLOTS_DEF
                                                             : int'(gen_table.active);
            repeat (54) begin
                r = $urandom_range(0, 99);
                if (r < 35) begin
                    queue_req(stia_pkg::FUNC_ADD,
                              stia_pkg::KEY_W'($urandom_range(0, 65535)));
                end else if (r < 85) begin
                    f = (r < 60) ? stia_pkg::FUNC_FIND : stia_pkg::FUNC_REMOVE;
                    if ($urandom_range(0, 9) < 8) begin
                        // mostly hit a live id, sometimes one parked in an inactive slot
                        bound = ($urandom_range(0, 3) == 0) ? stia_pkg::SLOTS_DEF : nact;
                        nlive = 0;
                        for (int i = 0; i < bound; i++) begin
                            if (gen_table.used[i]) begin
                                live[nlive] = gen_table.ids[i];
                                nlive++;
                            end
                        end
                        key = (nlive != 0) ? live[$urandom_range(0, nlive - 1)]
                                           : stia_pkg::KEY_W'($urandom_range(1, 65535));
                    end else begin
                        key = ($urandom_range(0, 3) == 0)
                              ? '0 : stia_pkg::KEY_W'($urandom_range(0, 65535));
                    end
                    queue_req(f, key);
                end else if (r < 90) begin
                    queue_req(stia_pkg::FUNC_CLEAR,
                              stia_pkg::KEY_W'($urandom_range(0, 65535)));
                end else begin
                    queue_req(stia_pkg::t_func'($urandom_range(0, 3)),
                              stia_pkg::KEY_W'($urandom_range(0, 65535)));
                end
            end
        end

        // saturated active count, then a narrowed and an empty window
        set_active(5'd31);
        req_gap_pct   = 18;
        rsp_stall_pct = 18;
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_FIND, 16'hFFFF);
        queue_req(stia_pkg::FUNC_REMOVE, 16'hFFFE);
        queue_req(stia_pkg::FUNC_ADD, '0);
        set_active(5'd13);
        queue_req(stia_pkg::FUNC_ADD, '0);
        set_active(5'd0);
        queue_req(stia_pkg::FUNC_ADD, '0);
        queue_req(stia_pkg::FUNC_FIND, 16'hFFFF);
        set_active(5'd16);
        queue_req(stia_pkg::FUNC_CLEAR, '0);
        queue_req(stia_pkg::FUNC_ADD, '0);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("slot_table_id_allocator_unit regression: pass");
        end else begin
            $display("slot_table_id_allocator_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("slot_table_id_allocator_unit regression: fail");
        $finish;
    end

endmodule
